FILE: design/decision_tree_classifier_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decision tree classifier checks
// Each macro samples on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DECISION_TREE_CLASSIFIER_ASSERT_SVH
`define DECISION_TREE_CLASSIFIER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DTC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DTC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// Word types, operation codes and status codes of the decision tree
// classifier.
// ----------------------------------------------------------------------------
package dtc_pkg;

  typedef logic [1:0] op_t;
  typedef logic [5:0] slot_t;
  typedef logic [3:0] fslot_t;
  typedef logic [3:0] class_t;
  typedef logic [1:0] status_t;
  typedef logic [5:0] depth_t;

  localparam op_t OP_WRITE_NODE    = 2'd0;
  localparam op_t OP_WRITE_FEATURE = 2'd1;
  localparam op_t OP_CLASSIFY      = 2'd2;
  localparam op_t OP_NONE          = 2'd3;

  localparam status_t ST_WRITE_DONE = 2'd0;
  localparam status_t ST_LEAF       = 2'd1;
  localparam status_t ST_MISSING    = 2'd2;
  localparam status_t ST_DEPTH      = 2'd3;

  localparam depth_t DEPTH_RESET = 6'd63;

  typedef struct packed {
    op_t                op;
    slot_t              node_slot;
    fslot_t             feature_slot;
    logic signed [31:0] number;
    slot_t              left_slot;
    slot_t              right_slot;
    logic               leaf_flag;
    class_t             class_label;
  } cmd_word_t;

  typedef struct packed {
    status_t status;
    class_t  result_class;
    slot_t   result_node;
    slot_t   path_length;
  } res_word_t;

endpackage

FILE: design/dtc_chan_if.sv
// ----------------------------------------------------------------------------
// dtc_chan_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface dtc_chan_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/decision_tree_classifier.sv
// ----------------------------------------------------------------------------
// decision_tree_classifier
// Decision tree inference engine with a loadable node table and features.
//
// cmd carries one word per operation: write node, write feature or
// classify; op code 3 is dropped without a result. res returns one word
// per write or classify. The user is to write the depth limit on cfg only
// while the block is idle; the block does not enforce this. cfg is always ready.
// A write passes through S_DONE before res is set valid. In a classify,
// each tree level costs a node memory read, a feature memory read and the
// signed compare that picks the child; these three steps run in turn on
// the one walk sequencer. cmd.ready is high only while no operation is in
// flight.
// res is a register: the next cmd word is taken while a result waits, and
// a finished result holds in the sequencer until res frees up.
// Reset clears all feature valid marks, sets the depth limit to 63 and
// empties res; node and feature memories keep their contents and need no
// clearing pass.
// ----------------------------------------------------------------------------
module decision_tree_classifier #(
  parameter int NODE_COUNT    = 64,
  parameter int FEATURE_COUNT = 16
) (
  input logic clk,
  input logic rst,
  dtc_chan_if.sink   cmd,
  dtc_chan_if.source res,
  dtc_chan_if.sink   cfg
);

  localparam int NW        = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int FW        = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int CLS_LSB   = 0;
  localparam int LEAF_BIT  = 4;
  localparam int RIGHT_LSB = 5;
  localparam int LEFT_LSB  = RIGHT_LSB + NW;
  localparam int THR_LSB   = LEFT_LSB + NW;
  localparam int FEAT_LSB  = THR_LSB + 32;
  localparam int NE        = FEAT_LSB + FW;
  localparam int SLOTS     = 64;
  localparam int FSLOTS    = 16;

  typedef enum logic [2:0] {S_IDLE, S_NODE, S_TEST, S_CMP, S_DONE} state_t;

  state_t                state;
  logic [NW-1:0]         cur;
  dtc_pkg::slot_t        steps;
  dtc_pkg::depth_t       depth_limit;
  logic [FEATURE_COUNT-1:0] fvalid;
  dtc_pkg::res_word_t    pend;

  logic [NW-1:0] node_wrap [SLOTS];
  logic [FW-1:0] feat_wrap [FSLOTS];

  logic          take;
  logic          emit;
  logic          node_we;
  logic          feat_we;
  logic [NE-1:0] node_wdata;
  logic [NE-1:0] node_rd;
  logic [31:0]   feat_rd;
  logic [FW-1:0] node_feat;
  logic [31:0]   node_thr;
  logic [NW-1:0] node_left;
  logic [NW-1:0] node_right;
  logic          node_leaf;
  dtc_pkg::class_t node_cls;
  logic          go_left;

  for (genvar i = 0; i < SLOTS; i++) begin : g_node_wrap
    assign node_wrap[i] = NW'(i % NODE_COUNT);
  end
  for (genvar i = 0; i < FSLOTS; i++) begin : g_feat_wrap
    assign feat_wrap[i] = FW'(i % FEATURE_COUNT);
  end

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign take      = cmd.valid && cmd.ready;
  assign emit      = (state == S_DONE) && (!res.valid || res.ready);
  assign node_we   = take && (cmd.data.op == dtc_pkg::OP_WRITE_NODE);
  assign feat_we   = take && (cmd.data.op == dtc_pkg::OP_WRITE_FEATURE);

  assign node_wdata = {feat_wrap[cmd.data.feature_slot], cmd.data.number,
                       node_wrap[cmd.data.left_slot], node_wrap[cmd.data.right_slot],
                       cmd.data.leaf_flag, cmd.data.class_label};

  assign node_feat  = node_rd[FEAT_LSB +: FW];
  assign node_thr   = node_rd[THR_LSB +: 32];
  assign node_left  = node_rd[LEFT_LSB +: NW];
  assign node_right = node_rd[RIGHT_LSB +: NW];
  assign node_leaf  = node_rd[LEAF_BIT];
  assign node_cls   = node_rd[CLS_LSB +: 4];
  assign go_left    = $signed(feat_rd) <= $signed(node_thr);

  dtc_ram #(.DEPTH(NODE_COUNT), .WIDTH(NE)) u_node_ram (
    .clk     (clk),
    .wr_en   (node_we),
    .wr_addr (node_wrap[cmd.data.node_slot]),
    .wr_data (node_wdata),
    .rd_addr (cur),
    .rd_data (node_rd)
  );

  dtc_ram #(.DEPTH(FEATURE_COUNT), .WIDTH(32)) u_feat_ram (
    .clk     (clk),
    .wr_en   (feat_we),
    .wr_addr (feat_wrap[cmd.data.feature_slot]),
    .wr_data (cmd.data.number),
    .rd_addr (node_feat),
    .rd_data (feat_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fvalid      <= '0;
      depth_limit <= dtc_pkg::DEPTH_RESET;
      res.valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        depth_limit <= cfg.data;
      end
      if (emit) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cur   <= '0;
          steps <= '0;
          pend  <= '0;
          if (take) begin
            case (cmd.data.op)
              dtc_pkg::OP_WRITE_NODE: state <= S_DONE;
              dtc_pkg::OP_WRITE_FEATURE: begin
                fvalid[feat_wrap[cmd.data.feature_slot]] <= 1'b1;
                state <= S_DONE;
              end
              dtc_pkg::OP_CLASSIFY: state <= S_NODE;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_NODE: state <= S_TEST;
        S_TEST: begin
          pend.result_node <= dtc_pkg::slot_t'(cur);
          pend.path_length <= steps;
          if (node_leaf) begin
            pend.status       <= dtc_pkg::ST_LEAF;
            pend.result_class <= node_cls;
            state             <= S_DONE;
          end else if (steps >= depth_limit) begin
            pend.status <= dtc_pkg::ST_DEPTH;
            state       <= S_DONE;
          end else if (!fvalid[node_feat]) begin
            pend.status <= dtc_pkg::ST_MISSING;
            state       <= S_DONE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          cur   <= go_left ? node_left : node_right;
          steps <= steps + 6'd1;
          state <= S_NODE;
        end
        S_DONE: begin
          if (emit) begin
            res.data <= pend;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/dtc_ram.sv
// ----------------------------------------------------------------------------
// dtc_ram
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module dtc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/dtc_checker.sv
// ----------------------------------------------------------------------------
// dtc_checker
// Port-level checks of the decision tree classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "decision_tree_classifier_assert.svh"

module dtc_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input dtc_pkg::op_t      cmd_op,
  input logic              res_valid,
  input logic              res_ready,
  input dtc_pkg::status_t  res_status,
  input dtc_pkg::class_t   res_class,
  input dtc_pkg::slot_t    res_node,
  input dtc_pkg::slot_t    res_path
);

  `DTC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "res word dropped while stalled")

  `DTC_ASSERT_NEXT(a_busy_after_take, cmd_valid && cmd_ready && cmd_op != dtc_pkg::OP_NONE, !cmd_ready, "cmd taken again while busy")

  `DTC_ASSERT_IMP(a_class_only_leaf, res_valid && res_status != dtc_pkg::ST_LEAF, res_class == 4'd0, "class set without leaf")

  `DTC_ASSERT_IMP(a_write_clean, res_valid && res_status == dtc_pkg::ST_WRITE_DONE, res_node == 6'd0 && res_path == 6'd0, "write result carries walk data")

endmodule

bind decision_tree_classifier dtc_checker u_dtc_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .cmd_op     (cmd.data.op),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_status (res.data.status),
  .res_class  (res.data.result_class),
  .res_node   (res.data.result_node),
  .res_path   (res.data.path_length)
);
